@@ src/pixel_to_ansi_terminal_encoder_macros.svh @@
`ifndef PIXEL_TO_ANSI_TERMINAL_ENCODER_MACROS_SVH
`define PIXEL_TO_ANSI_TERMINAL_ENCODER_MACROS_SVH

// Check that b holds in the same cycle as a.
`define P2A_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("p2a check failed");

// Check that b holds in the cycle after a.
`define P2A_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("p2a check failed");

`endif

@@ src/p2a_pkg.sv @@
package p2a_pkg;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_ONE      = 8'h31;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [7:0] FRAME_WIDTH_RST  = 8'd80;
    localparam logic [7:0] FRAME_HEIGHT_RST = 8'd24;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_CRLF,
        PFX_HOME
    } prefix_t;

    typedef struct packed {
        prefix_t    prefix;
        logic       color_change;
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_FIRST,
        ST_HOME_ESC,
        ST_HOME_LB,
        ST_HOME_ROW,
        ST_HOME_SEMI,
        ST_HOME_COL,
        ST_HOME_H,
        ST_CR,
        ST_LF,
        ST_ESC,
        ST_LB,
        ST_HUND,
        ST_TENS,
        ST_ONES,
        ST_M,
        ST_SPACE
    } step_t;

endpackage

@@ src/p2a_front.sv @@
module p2a_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        pixel_color,
    input  logic              cfg_valid,
    input  logic [0:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output p2a_pkg::cmd_t     q_cmd
);

    logic [7:0] frame_width_reg;
    logic [7:0] frame_height_reg;
    logic [7:0] column_count_reg;
    logic [7:0] column_count_next;
    logic [7:0] row_count_reg;
    logic [7:0] row_count_next;
    logic [7:0] color_reg;
    logic [7:0] color_next;

    logic              frame_start;
    logic [7:0]        cmp_color;
    logic [1:0]        hund;
    logic [6:0]        rem;
    logic [14:0]       tens_prod;
    logic [3:0]        tens;
    logic [6:0]        ones_full;
    logic [8:0]        col_inc;
    logic [8:0]        row_inc;
    logic [8:0]        wlim;
    logic [8:0]        hlim;

    assign q_push = push && !q_full;

    always_comb
    begin
        frame_start = (column_count_reg == 8'd0) && (row_count_reg == 8'd0);
        cmp_color   = frame_start ? 8'd0 : color_reg;

        if (pixel_color >= 8'd200)
        begin
            hund = 2'd2;
            rem  = 7'(pixel_color - 8'd200);
        end
        else if (pixel_color >= 8'd100)
        begin
            hund = 2'd1;
            rem  = 7'(pixel_color - 8'd100);
        end
        else
        begin
            hund = 2'd0;
            rem  = pixel_color[6:0];
        end
        tens_prod = 15'({8'd0, rem} * 15'd205);
        tens      = tens_prod[14:11];
        ones_full = 7'(rem - 7'({3'd0, tens} * 7'd10));

        if (frame_start)
            q_cmd.prefix = p2a_pkg::PFX_HOME;
        else if (column_count_reg == 8'd0)
            q_cmd.prefix = p2a_pkg::PFX_CRLF;
        else
            q_cmd.prefix = p2a_pkg::PFX_NONE;
        q_cmd.color_change = (pixel_color != cmp_color);
        q_cmd.hund         = hund;
        q_cmd.tens         = tens;
        q_cmd.ones         = ones_full[3:0];

        wlim    = (frame_width_reg == 8'd0) ? 9'd256 : {1'b0, frame_width_reg};
        hlim    = (frame_height_reg == 8'd0) ? 9'd256 : {1'b0, frame_height_reg};
        col_inc = {1'b0, column_count_reg} + 9'd1;
        row_inc = {1'b0, row_count_reg} + 9'd1;

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        color_next        = color_reg;
        if (q_push)
        begin
            color_next = pixel_color;
            if (col_inc >= wlim)
            begin
                column_count_next = 8'd0;
                row_count_next    = (row_inc >= hlim) ? 8'd0 : row_inc[7:0];
            end
            else
            begin
                column_count_next = col_inc[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= p2a_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= p2a_pkg::FRAME_HEIGHT_RST;
            column_count_reg <= 8'd0;
            row_count_reg    <= 8'd0;
            color_reg        <= 8'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                priority if (cfg_index == p2a_pkg::REG_FRAME_WIDTH)
                    frame_width_reg <= cfg_data;
                else if (cfg_index == p2a_pkg::REG_FRAME_HEIGHT)
                    frame_height_reg <= cfg_data;
            end
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            color_reg        <= color_next;
        end
    end

endmodule

@@ src/p2a_cmd_fifo.sv @@
module p2a_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  p2a_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          rd_en,
    output p2a_pkg::cmd_t rd_cmd,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    p2a_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full   = (count_reg == CNT_FULL);
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ src/p2a_back.sv @@
module p2a_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  p2a_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    out_byte,
    output logic          last_byte
);

    p2a_pkg::step_t step_reg;
    p2a_pkg::step_t step_next;
    p2a_pkg::step_t cur_step;
    p2a_pkg::step_t after_prefix;
    p2a_pkg::step_t after_lb;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     byte_reg;
    logic [7:0]     byte_next;
    logic           last_reg;
    logic           fire;

    assign empty     = !out_valid_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

    always_comb
    begin
        after_prefix = q_cmd.color_change ? p2a_pkg::ST_ESC : p2a_pkg::ST_SPACE;
        if (q_cmd.hund != 2'd0)
            after_lb = p2a_pkg::ST_HUND;
        else if (q_cmd.tens != 4'd0)
            after_lb = p2a_pkg::ST_TENS;
        else if (q_cmd.ones != 4'd0)
            after_lb = p2a_pkg::ST_ONES;
        else
            after_lb = p2a_pkg::ST_M;

        if (step_reg != p2a_pkg::ST_FIRST)
            cur_step = step_reg;
        else
        begin
            unique case (q_cmd.prefix)
                p2a_pkg::PFX_HOME: cur_step = p2a_pkg::ST_HOME_ESC;
                p2a_pkg::PFX_CRLF: cur_step = p2a_pkg::ST_CR;
                default:           cur_step = after_prefix;
            endcase
        end

        fire  = !q_empty && (!out_valid_reg || pop);
        q_pop = fire && (cur_step == p2a_pkg::ST_SPACE);

        unique case (cur_step)
            p2a_pkg::ST_FIRST:     begin byte_next = p2a_pkg::CH_SPACE;    step_next = after_prefix;           end
            p2a_pkg::ST_HOME_ESC:  begin byte_next = p2a_pkg::CH_ESC;      step_next = p2a_pkg::ST_HOME_LB;    end
            p2a_pkg::ST_HOME_LB:   begin byte_next = p2a_pkg::CH_LBRACKET; step_next = p2a_pkg::ST_HOME_ROW;   end
            p2a_pkg::ST_HOME_ROW:  begin byte_next = p2a_pkg::CH_ONE;      step_next = p2a_pkg::ST_HOME_SEMI;  end
            p2a_pkg::ST_HOME_SEMI: begin byte_next = p2a_pkg::CH_SEMI;     step_next = p2a_pkg::ST_HOME_COL;   end
            p2a_pkg::ST_HOME_COL:  begin byte_next = p2a_pkg::CH_ONE;      step_next = p2a_pkg::ST_HOME_H;     end
            p2a_pkg::ST_HOME_H:    begin byte_next = p2a_pkg::CH_H;        step_next = after_prefix;           end
            p2a_pkg::ST_CR:        begin byte_next = p2a_pkg::CH_CR;       step_next = p2a_pkg::ST_LF;         end
            p2a_pkg::ST_LF:        begin byte_next = p2a_pkg::CH_LF;       step_next = after_prefix;           end
            p2a_pkg::ST_ESC:       begin byte_next = p2a_pkg::CH_ESC;      step_next = p2a_pkg::ST_LB;         end
            p2a_pkg::ST_LB:        begin byte_next = p2a_pkg::CH_LBRACKET; step_next = after_lb;               end
            p2a_pkg::ST_HUND:
            begin
                byte_next = p2a_pkg::CH_ZERO + {6'd0, q_cmd.hund};
                step_next = p2a_pkg::ST_TENS;
            end
            p2a_pkg::ST_TENS:
            begin
                byte_next = p2a_pkg::CH_ZERO + {4'd0, q_cmd.tens};
                step_next = p2a_pkg::ST_ONES;
            end
            p2a_pkg::ST_ONES:
            begin
                byte_next = p2a_pkg::CH_ZERO + {4'd0, q_cmd.ones};
                step_next = p2a_pkg::ST_M;
            end
            p2a_pkg::ST_M:         begin byte_next = p2a_pkg::CH_M;        step_next = p2a_pkg::ST_SPACE;      end
            p2a_pkg::ST_SPACE:     begin byte_next = p2a_pkg::CH_SPACE;    step_next = p2a_pkg::ST_FIRST;      end
        endcase

        if (!fire)
            step_next = step_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= p2a_pkg::ST_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= byte_next;
            last_reg <= (cur_step == p2a_pkg::ST_SPACE);
        end
    end

endmodule

@@ src/pixel_to_ansi_terminal_encoder.sv @@
// Turns raster-order pixel color codes into an ANSI terminal byte stream. Each pixel
// pushed becomes 1 to 13 bytes: cursor home on the first pixel of a frame, CR LF at
// the start of each later row, a color escape when the color changes, and a closing
// space flagged by last_byte. Pixels are taken while the command queue (CMD_DEPTH
// entries) has room; the byte sequencer drains the queue at one byte per cycle while
// pop is held, and a pixel has 1 byte for an unchanged color inside a row, up to 9
// in the middle of a frame, 13 at most. Registers: index 0 frame width, index 1 frame
// height, 0 meaning 256; write them only while the block is idle.
module pixel_to_ansi_terminal_encoder #(
    parameter int CMD_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] pixel_color,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    p2a_pkg::cmd_t wr_cmd;
    p2a_pkg::cmd_t rd_cmd;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    p2a_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pixel_color (pixel_color),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (wr_cmd)
    );

    p2a_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (wr_cmd),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_cmd (rd_cmd),
        .empty  (q_empty)
    );

    p2a_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (rd_cmd),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

@@ src/p2a_checker.sv @@
`include "pixel_to_ansi_terminal_encoder_macros.svh"

module p2a_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       last_byte
);

    `P2A_ASSERT_NEXT(a_hold_stalled, clk, rst_n, !empty && !pop,
        !empty && $stable(out_byte) && $stable(last_byte))
    `P2A_ASSERT_SAME(a_last_is_space, clk, rst_n, !empty && last_byte,
        out_byte == p2a_pkg::CH_SPACE)
    `P2A_ASSERT_NEXT(a_esc_then_bracket, clk, rst_n,
        !empty && pop && out_byte == p2a_pkg::CH_ESC,
        !empty && out_byte == p2a_pkg::CH_LBRACKET)

endmodule

bind pixel_to_ansi_terminal_encoder p2a_checker u_p2a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .last_byte (last_byte)
);

@@ tb/pixel_to_ansi_terminal_encoder_test.sv @@
`timescale 1ns / 1ps

module pixel_to_ansi_terminal_encoder_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } term_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] pixel_color = 8'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_byte;
    logic       last_byte;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = p2a_pkg::REG_FRAME_WIDTH;
    logic [7:0] cfg_data = 8'd0;

    // Encoder state tracked on the testbench side
    logic [7:0] width_cfg = p2a_pkg::FRAME_WIDTH_RST;
    logic [7:0] height_cfg = p2a_pkg::FRAME_HEIGHT_RST;
    logic [7:0] next_col = 8'd0;
    logic [7:0] next_row = 8'd0;
    logic [7:0] shown_color = 8'd0;

    term_byte_t pending_bytes[$];

    bit idle_on = 1'b1;
    int cycles = 0;
    int mismatches = 0;
    int pixels_sent = 0;
    int bytes_checked = 0;
    int size_settings = 0;

    pixel_to_ansi_terminal_encoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_color(pixel_color),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .last_byte  (last_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_byte(input logic [7:0] data, input logic last);
        pending_bytes.push_back('{data: data, last: last});
    endfunction

    function automatic void encode_pixel(input logic [7:0] color);
        logic [8:0] wlim;
        logic [8:0] hlim;
        logic [7:0] hund;
        logic [7:0] tens;
        logic [7:0] ones;
        wlim = (width_cfg == 8'd0) ? 9'd256 : {1'b0, width_cfg};
        hlim = (height_cfg == 8'd0) ? 9'd256 : {1'b0, height_cfg};
        if (next_col == 8'd0 && next_row == 8'd0)
        begin
            add_byte(p2a_pkg::CH_ESC, 1'b0);
            add_byte(p2a_pkg::CH_LBRACKET, 1'b0);
            add_byte(p2a_pkg::CH_ONE, 1'b0);
            add_byte(p2a_pkg::CH_SEMI, 1'b0);
            add_byte(p2a_pkg::CH_ONE, 1'b0);
            add_byte(p2a_pkg::CH_H, 1'b0);
            shown_color = 8'd0;
        end
        else if (next_col == 8'd0)
        begin
            add_byte(p2a_pkg::CH_CR, 1'b0);
            add_byte(p2a_pkg::CH_LF, 1'b0);
        end
        if (color != shown_color)
        begin
            shown_color = color;
            hund = color / 8'd100;
            tens = (color / 8'd10) % 8'd10;
            ones = color % 8'd10;
            add_byte(p2a_pkg::CH_ESC, 1'b0);
            add_byte(p2a_pkg::CH_LBRACKET, 1'b0);
            if (hund != 8'd0)
                add_byte(p2a_pkg::CH_ZERO + hund, 1'b0);
            if (tens != 8'd0 || hund != 8'd0)
                add_byte(p2a_pkg::CH_ZERO + tens, 1'b0);
            if (ones != 8'd0 || tens != 8'd0 || hund != 8'd0)
                add_byte(p2a_pkg::CH_ZERO + ones, 1'b0);
            add_byte(p2a_pkg::CH_M, 1'b0);
        end
        add_byte(p2a_pkg::CH_SPACE, 1'b1);
        if ({1'b0, next_col} + 9'd1 >= wlim)
        begin
            next_col = 8'd0;
            if ({1'b0, next_row} + 9'd1 >= hlim)
                next_row = 8'd0;
            else
                next_row = next_row + 8'd1;
        end
        else
        begin
            next_col = next_col + 8'd1;
        end
    endfunction

    function automatic logic [7:0] pick_color();
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3: return shown_color;
            4:          return 8'd0;
            5:          return 8'($urandom_range(1, 9));
            6:          return 8'($urandom_range(10, 99));
            7:          return 8'($urandom_range(100, 255));
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] color);
        while (idle_on && $urandom_range(0, 99) < 9)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        encode_pixel(color);
        push <= 1'b1;
        pixel_color <= color;
        do @(posedge clk); while (full);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_size(input logic [7:0] w, input logic [7:0] h);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= p2a_pkg::REG_FRAME_WIDTH;
        cfg_data <= w;
        do @(posedge clk); while (!cfg_ready);
        width_cfg = w;
        cfg_index <= p2a_pkg::REG_FRAME_HEIGHT;
        cfg_data <= h;
        do @(posedge clk); while (!cfg_ready);
        height_cfg = h;
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd7);
        send_pixel(8'd42);
        send_pixel(8'd100);
        send_pixel(8'd0);
    endtask

    task automatic test_row_and_frame_wrap();
        set_frame_size(8'd3, 8'd2);
        send_pixel(8'd9);
        send_pixel(8'd10);
        send_pixel(8'd99);
        send_pixel(8'd99);
        send_pixel(8'd200);
        send_pixel(8'd1);
        send_pixel(8'd1);
    endtask

    task automatic test_size_shrink();
        // one-pixel frames: home on every pixel, color forgotten each time
        set_frame_size(8'd1, 8'd1);
        send_pixel(8'd5);
        send_pixel(8'd5);
        send_pixel(8'd0);
        set_frame_size(8'd6, 8'd4);
        repeat (5) send_pixel(8'd3);
        // column already past the new width
        set_frame_size(8'd3, 8'd4);
        send_pixel(8'd3);
        send_pixel(8'd4);
        set_frame_size(8'd1, 8'd8);
        repeat (3) send_pixel(8'd4);
        // row already past the new height
        set_frame_size(8'd1, 8'd2);
        send_pixel(8'd4);
        send_pixel(8'd4);
    endtask

    task automatic test_random_frames();
        logic [7:0] w;
        logic [7:0] h;
        for (int phase = 0; phase < 6; phase++)
        begin
            w = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                            : 8'($urandom_range(1, 6));
            h = 8'($urandom_range(1, 5));
            set_frame_size(w, h);
            idle_on = (phase != 2);
            repeat (18) send_pixel(pick_color());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_max_sizes();
        set_frame_size(8'd255, 8'd255);
        repeat (6) send_pixel(pick_color());
        // zero width means 256 columns
        set_frame_size(8'd0, 8'd1);
        repeat (6) send_pixel(pick_color());
        // zero height means 256 rows
        set_frame_size(8'd1, 8'd0);
        repeat (6) send_pixel(pick_color());
    endtask

    always @(posedge clk)
    begin
        term_byte_t want;
        pop <= !idle_on || ($urandom_range(0, 99) >= 9);
        if (rst_n && pop && !empty)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte: out_byte %h last_byte %b", out_byte, last_byte);
                mismatches++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %h, got %h", want.data, out_byte);
                    mismatches++;
                end
                if (last_byte !== want.last)
                begin
                    $error("last_byte: expected %b, got %b", want.last, last_byte);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pixel_to_ansi_terminal_encoder_test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_row_and_frame_wrap();
        test_size_shrink();
        test_random_frames();
        test_max_sizes();
        wait_idle();
        $display("%0d pixels encoded into %0d checked terminal bytes", pixels_sent,
                 bytes_checked);
        $display("over %0d frame size settings, zero and full-range sizes included",
                 size_settings);
        if (mismatches == 0)
            $display("pixel_to_ansi_terminal_encoder_test passed");
        else
            $display("pixel_to_ansi_terminal_encoder_test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/p2a_pkg.sv
src/p2a_front.sv
src/p2a_cmd_fifo.sv
src/p2a_back.sv
src/pixel_to_ansi_terminal_encoder.sv
src/p2a_checker.sv
tb/pixel_to_ansi_terminal_encoder_test.sv
